// File: src/wake_score_window_detector_macros.svh
// Assertion macros for the wake score window detector.
// Used by src/wake_score_window_detector.sv; assumes a clock named aclk and reset aresetn.
`ifndef WAKE_SCORE_WINDOW_DETECTOR_MACROS_SVH
`define WAKE_SCORE_WINDOW_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define WSWD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define WSWD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define WSWD_ASSERT(label, prop, msg)
`define WSWD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: src/wswd_pkg.sv
// Shared types and constants of the wake score window detector.
// No dependencies; imported by src/wake_score_window_detector.sv.
package wswd_pkg;

    localparam int SCORE_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // request action codes
    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_EVAL  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_CUTOFF = 2'd2;

    localparam logic [4:0]         WINDOW_SIZE_RST  = 5'd10;
    localparam logic [SCORE_W-1:0] FRAME_STRIDE_RST = 8'd3;
    localparam logic [SCORE_W-1:0] SCORE_CUTOFF_RST = 8'd200;

    typedef struct packed {
        logic [1:0]         action;
        logic [SCORE_W-1:0] score;
    } in_item_t;

    typedef struct packed {
        logic               evaluated;
        logic               detected;
        logic [SCORE_W-1:0] peak_score;
        logic [SCORE_W-1:0] mean_score;
        logic               stored;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DIV,
        ST_POST
    } state_t;

endpackage

// File: src/wake_score_window_detector.sv
// Top level of the wake score window detector: score ring memory, scan and divider.
// Depends on src/wswd_pkg.sv and src/wake_score_window_detector_macros.svh.
`include "wake_score_window_detector_macros.svh"

// Wake score window detector. Each request carries an action and a score.
// A frame request advances the stride and ring phases; on every frame_stride-th
// frame it writes the score into the ring entry picked by the ring phase and
// answers stored = 1. An evaluate request walks the first window_size ring
// entries (one synchronous memory read per cycle), keeps the running sum and
// peak, then divides the sum by the window size one quotient bit per cycle.
// It reports peak, floor mean and whether the sum exceeds
// score_cutoff * window_size, but only for the first evaluation after a reset;
// later evaluations answer zeros. A clear request empties the ring (per-entry
// valid bits drop at once, so there is no clearing pass) and rearms the
// evaluation. Every request gives exactly one result. Frame, clear, unknown
// and non-reporting evaluate requests pass through accept, execute and post;
// a reporting evaluation passes through accept, execute, scan, divide and
// post, its length set by the single ring read port (one entry per cycle,
// plus draining the read pipeline) and the one-bit-per-cycle divider. One
// request is processed at a time; a new request is taken while an earlier
// result still waits in the output register. Configuration writes are always
// ready and must be issued only while the block is idle.
module wake_score_window_detector #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wswd_pkg::in_item_t                  s_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output wswd_pkg::out_item_t                 m_data,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wswd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wswd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import wswd_pkg::*;

    // address width of the ring, count width able to hold MAX_WINDOW itself
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    // sum of up to MAX_WINDOW scores
    localparam int SUM_W = SCORE_W + CNT_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [4:0]         window_size_reg;
    logic [SCORE_W-1:0] frame_stride_reg;
    logic [SCORE_W-1:0] score_cutoff_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg  <= WINDOW_SIZE_RST;
            frame_stride_reg <= FRAME_STRIDE_RST;
            score_cutoff_reg <= SCORE_CUTOFF_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WINDOW_SIZE:  window_size_reg  <= cfg_wdata[4:0];
                REG_FRAME_STRIDE: frame_stride_reg <= cfg_wdata;
                REG_SCORE_CUTOFF: score_cutoff_reg <= cfg_wdata;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Effective window: zero acts as one, clamp to the ring depth.
    logic [CNT_W-1:0]   w_eff;
    logic [SCORE_W-1:0] s_eff;

    always_comb begin
        if (window_size_reg == 5'd0) begin
            w_eff = CNT_W'(1);
        end else if (int'(window_size_reg) > MAX_WINDOW) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(window_size_reg);
        end
        s_eff = (frame_stride_reg == '0) ? SCORE_W'(1) : frame_stride_reg;
    end

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t              state_reg, state_next;
    in_item_t            item_reg;
    out_item_t           res_reg;
    logic [SCORE_W-1:0]  stride_phase_reg;
    logic [IDX_W-1:0]    ring_phase_reg;
    logic                eval_done_reg;

    // ring memory with one valid bit per entry; a never-written or cleared
    // entry reads as zero
    logic [SCORE_W-1:0]    ring_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] live_reg;
    logic [SCORE_W-1:0]    rd_data_reg;
    logic                  rd_live_reg;

    // scan and divide datapath
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic                rd_pend_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SCORE_W-1:0]  peak_reg;
    logic [SUM_W-1:0]    thr_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    dvs_reg;
    logic [SCORE_W-1:0]  quo_reg;
    logic [2:0]          div_cnt_reg;

    // output register
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // Frame phase arithmetic
    // ---------------------------------------------------------------
    logic [SCORE_W:0] sp_sum;
    logic [CNT_W-1:0] rp_sum;
    logic             sp_wrap;
    logic             rp_wrap;
    logic [IDX_W-1:0] rp_new;

    always_comb begin
        sp_sum  = {1'b0, stride_phase_reg} + (SCORE_W+1)'(1);
        rp_sum  = CNT_W'(ring_phase_reg) + CNT_W'(1);
        sp_wrap = (sp_sum >= {1'b0, s_eff});
        rp_wrap = (rp_sum >= w_eff);
        rp_new  = rp_wrap ? '0 : rp_sum[IDX_W-1:0];
    end

    // ---------------------------------------------------------------
    // Scan progress and divider step
    // ---------------------------------------------------------------
    logic               scan_issue;
    logic               scan_done;
    logic [SCORE_W-1:0] rd_val;
    logic [SUM_W-1:0]   rem_sub;
    logic               quo_bit;
    logic               div_last;

    always_comb begin
        scan_issue = (scan_cnt_reg < w_eff);
        scan_done  = !scan_issue && !rd_pend_reg;
        rd_val     = rd_live_reg ? rd_data_reg : '0;
        quo_bit    = (rem_reg >= dvs_reg);
        rem_sub    = rem_reg - dvs_reg;
        div_last   = (div_cnt_reg == 3'd0);
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (item_reg.action == ACT_EVAL && !eval_done_reg) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_POST;
                end
            end
            ST_SCAN: begin
                if (scan_done) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_last) state_next = ST_POST;
            end
            ST_POST: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Control outputs
    // ---------------------------------------------------------------
    logic             mem_we;
    logic [IDX_W-1:0] rd_addr;
    logic             out_load;

    always_comb begin
        s_ready  = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        rd_addr  = scan_cnt_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: mem_we  = (item_reg.action == ACT_FRAME) && sp_wrap;
            ST_SCAN: ;
            ST_DIV:  ;
            ST_POST: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Ring memory: one write port, one registered read port
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[rp_new] <= item_reg.score;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            rd_live_reg <= 1'b0;
        end else begin
            rd_live_reg <= live_reg[rd_addr];
            if (state_reg == ST_EXEC && item_reg.action == ACT_CLEAR) begin
                live_reg <= '0;
            end else if (mem_we) begin
                live_reg[rp_new] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Phases and evaluation flag
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_phase_reg <= '0;
            ring_phase_reg   <= '0;
            eval_done_reg    <= 1'b0;
        end else if (state_reg == ST_EXEC) begin
            unique case (item_reg.action)
                ACT_FRAME: begin
                    stride_phase_reg <= sp_wrap ? '0 : sp_sum[SCORE_W-1:0];
                    ring_phase_reg   <= rp_new;
                end
                ACT_EVAL: eval_done_reg <= 1'b1;
                ACT_CLEAR: begin
                    stride_phase_reg <= '0;
                    ring_phase_reg   <= '0;
                    eval_done_reg    <= 1'b0;
                end
                default: ;  // unknown action: leave state alone
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Request capture, scan, divide and result assembly
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == ST_SCAN) && scan_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end

        unique case (state_reg)
            ST_EXEC: begin
                // default answer: all zeros, stored flag for a writing frame
                res_reg      <= '{evaluated: 1'b0, detected: 1'b0, peak_score: '0,
                                  mean_score: '0, stored: mem_we};
                scan_cnt_reg <= '0;
                sum_reg      <= '0;
                peak_reg     <= '0;
            end
            ST_SCAN: begin
                if (scan_issue) begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                if (rd_pend_reg) begin
                    sum_reg <= sum_reg + SUM_W'(rd_val);
                    if (rd_val > peak_reg) peak_reg <= rd_val;
                end
                if (scan_done) begin
                    // set up the divider: largest shifted divisor first
                    rem_reg     <= sum_reg;
                    dvs_reg     <= SUM_W'(w_eff) << (SCORE_W - 1);
                    thr_reg     <= SUM_W'(score_cutoff_reg) * SUM_W'(w_eff);
                    div_cnt_reg <= 3'(SCORE_W - 1);
                    quo_reg     <= '0;
                end
            end
            ST_DIV: begin
                if (quo_bit) rem_reg <= rem_sub;
                dvs_reg     <= dvs_reg >> 1;
                quo_reg     <= {quo_reg[SCORE_W-2:0], quo_bit};
                div_cnt_reg <= div_cnt_reg - 3'd1;
                if (div_last) begin
                    res_reg <= '{evaluated: 1'b1, detected: (sum_reg > thr_reg),
                                 peak_score: peak_reg,
                                 mean_score: {quo_reg[SCORE_W-2:0], quo_bit},
                                 stored: 1'b0};
                end
            end
            ST_IDLE: ;
            ST_POST: ;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Output register: hold until taken, reload as it drains
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `WSWD_ASSERT(a_mean_below_peak, m_valid |-> (m_data.mean_score <= m_data.peak_score), "mean above peak")
    `WSWD_ASSERT(a_detect_needs_eval, (m_valid && m_data.detected) |-> m_data.evaluated, "detect without evaluation")
    `WSWD_ASSERT(a_no_write_in_scan, (state_reg == ST_SCAN || state_reg == ST_DIV) |-> !mem_we, "ring write during evaluation")
    `WSWD_ASSERT(a_load_from_post, $rose(m_valid) |-> $past(state_reg == ST_POST), "result loaded outside post state")

endmodule

// File: tb/wake_score_window_detector_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for wake_score_window_detector: frame, evaluate and clear requests
// with random idling on both channels, each result checked against a local window predictor.
// Depends on src/wswd_pkg.sv and src/wake_score_window_detector.sv.
module wake_score_window_detector_test;
    import wswd_pkg::*;

    localparam int MAX_WIN        = 16;
    localparam int ITEM_TARGET    = 1900;
    localparam int QUIET_FROM     = 1600;   // no idling on either side past this many requests
    localparam int LONG_HOLD      = 250;    // receiver hold-off for the backpressure test
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;

    // action code the block ignores, and a register index it does not decode
    localparam logic [1:0]           ACT_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predictor copy of the block: score ring, the two phases, the one-shot evaluation flag
    // and the three registers.
    logic [SCORE_W-1:0] score_hist [MAX_WIN];
    logic [7:0]         stride_ph;
    logic [3:0]         ring_ph;
    logic               eval_done;
    logic [4:0]         win_reg;
    logic [7:0]         stride_reg;
    logic [7:0]         cutoff_reg;

    // Results predicted for accepted requests, oldest first.
    out_item_t pending_results [$];

    int mismatch_count = 0;
    int requests_sent  = 0;
    int settings_used  = 1;
    int evals_seen     = 0;
    int detects_seen   = 0;
    int stores_seen    = 0;
    int quiet_cycles   = 0;
    bit idle_on           = 1'b1;
    bit long_hold_pending = 1'b0;

    always #6 aclk = ~aclk;

    wake_score_window_detector #(.MAX_WINDOW(MAX_WIN)) uut (.*);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_window_model();
        for (int i = 0; i < MAX_WIN; i++) score_hist[i] = '0;
        stride_ph = '0;
        ring_ph   = '0;
        eval_done = 1'b0;
    endfunction

    // Advance the predictor by one request and return the result it must give.
    function automatic out_item_t predict_result(input in_item_t req);
        out_item_t   res;
        int unsigned w;
        int unsigned s;
        int unsigned sp;
        int unsigned rp;
        int unsigned sum;
        int unsigned peak;
        res = '0;
        // window 0 behaves as 1 and anything past the ring size as the ring size;
        // stride 0 behaves as 1
        w = (win_reg == 0) ? 1 : ((win_reg > MAX_WIN) ? MAX_WIN : win_reg);
        s = (stride_reg == 0) ? 1 : stride_reg;
        case (req.action)
            ACT_FRAME: begin
                // both phases wrap independently; a phase left out of range by a
                // register write wraps to zero on its next step
                sp = stride_ph + 1;
                rp = ring_ph + 1;
                if (sp >= s) sp = 0;
                if (rp >= w) rp = 0;
                stride_ph = sp[7:0];
                ring_ph   = rp[3:0];
                if (sp == 0) begin
                    score_hist[rp % MAX_WIN] = req.score;
                    res.stored = 1'b1;
                end
            end
            ACT_EVAL: begin
                // only the first evaluation after a clear reports figures
                if (!eval_done) begin
                    sum  = 0;
                    peak = 0;
                    for (int i = 0; i < w; i++) begin
                        if (score_hist[i] > peak) peak = score_hist[i];
                        sum += score_hist[i];
                    end
                    res.evaluated  = 1'b1;
                    res.detected   = (sum > cutoff_reg * w);
                    res.peak_score = peak[7:0];
                    res.mean_score = 8'(sum / w);
                    eval_done      = 1'b1;
                end
            end
            ACT_CLEAR: clear_window_model();
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one request, optionally after a sender gap, and hold it until accepted.
    // Returns at the accepting rising edge; the next call drives at the following fall.
    task automatic send_request(input logic [1:0] act, input logic [SCORE_W-1:0] sc);
        in_item_t req;
        int       gap;
        req.action = act;
        req.score  = sc;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_result(req));
        if (act != ACT_NONE) requests_sent++;
    endtask

    // Drop valid and wait until every predicted result has been delivered.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Write one register; call only while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_WINDOW_SIZE:  win_reg    = data[4:0];
            REG_FRAME_STRIDE: stride_reg = data;
            REG_SCORE_CUTOFF: cutoff_reg = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Frame run with either uniform scores or scores held high, to land on both sides
    // of the detection threshold.
    task automatic send_frames(input int count);
        bit hot;
        hot = $urandom_range(0, 1);
        repeat (count)
            send_request(ACT_FRAME, hot ? 8'($urandom_range(150, 255)) : 8'($urandom));
    endtask

    // Random frame count up to about a full window turn at the current setting, capped so a
    // huge stride does not eat the whole run.
    function automatic int frame_budget();
        int lim;
        lim = (int'(stride_reg) + 1) * (int'(win_reg) + 1) + 4;
        if (lim > 300) lim = 300;
        return $urandom_range(0, lim);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("ERROR at %0t: %s is %0d, predicted %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result side: receiver idling and checking
    // ------------------------------------------------------------------

    // Ready in random bursts of idling; a pending long hold takes priority once the
    // current burst ends and is counted out here.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare every delivered result with the oldest prediction, field by field.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result without a request", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.evaluated !== want.evaluated)
                    report_mismatch("evaluated", m_data.evaluated, want.evaluated);
                if (m_data.detected !== want.detected)
                    report_mismatch("detected", m_data.detected, want.detected);
                if (m_data.peak_score !== want.peak_score)
                    report_mismatch("peak_score", m_data.peak_score, want.peak_score);
                if (m_data.mean_score !== want.mean_score)
                    report_mismatch("mean_score", m_data.mean_score, want.mean_score);
                if (m_data.stored !== want.stored)
                    report_mismatch("stored", m_data.stored, want.stored);
                evals_seen   += want.evaluated;
                detects_seen += want.detected;
                stores_seen  += want.stored;
            end
        end
    end

    // End the run when no handshake of any kind completes for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake in %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: evaluation on an empty ring, the one-shot rule, the ignored
    // action, and a stored score after a clear.
    task automatic test_reset_defaults();
        send_request(ACT_EVAL, 8'h00);
        send_request(ACT_EVAL, 8'hFF);
        send_request(ACT_NONE, 8'hFF);
        repeat (3) send_request(ACT_FRAME, 8'hFF);
        send_request(ACT_CLEAR, 8'h00);
        repeat (3) send_request(ACT_FRAME, 8'h80);
        send_request(ACT_EVAL, 8'h00);
    endtask

    // Register extremes: window 0 and above the ring size, stride 0 and 255, cutoff at
    // both ends with the sum just over and just at the threshold, and an undecoded index.
    task automatic test_register_extremes();
        drain_results();
        write_register(REG_WINDOW_SIZE, 8'hE0);     // upper bits dropped, window 0
        write_register(REG_FRAME_STRIDE, 8'h00);
        write_register(REG_SCORE_CUTOFF, 8'd254);
        settings_used++;
        send_request(ACT_CLEAR, 8'h00);
        send_request(ACT_FRAME, 8'hFF);
        send_request(ACT_EVAL, 8'h00);              // 255 > 254, detect
        drain_results();
        write_register(REG_SCORE_CUTOFF, 8'd255);
        settings_used++;
        send_request(ACT_CLEAR, 8'h00);
        send_request(ACT_FRAME, 8'hFF);
        send_request(ACT_EVAL, 8'h00);              // 255 equals the threshold, no detect
        drain_results();
        write_register(REG_WINDOW_SIZE, 8'h1F);     // clamps to the ring size
        write_register(REG_FRAME_STRIDE, 8'hFF);
        write_register(REG_SCORE_CUTOFF, 8'h00);
        write_register(REG_UNUSED, 8'h5A);
        settings_used++;
        send_request(ACT_CLEAR, 8'h00);
        repeat (2) send_request(ACT_FRAME, 8'h01);
        send_request(ACT_EVAL, 8'h00);
    endtask

    // Hold the result side off for a long stretch while requests keep coming, so the
    // output register fills and the request side stalls.
    task automatic test_result_backpressure();
        drain_results();
        write_register(REG_WINDOW_SIZE, 8'd4);
        write_register(REG_FRAME_STRIDE, 8'd1);
        write_register(REG_SCORE_CUTOFF, 8'd100);
        settings_used++;
        long_hold_pending = 1'b1;
        send_request(ACT_CLEAR, 8'h00);
        send_frames(12);
        send_request(ACT_EVAL, 8'h00);
    endtask

    // Pick a new register setting, extremes included, with random upper write bits.
    task automatic pick_settings();
        logic [4:0] wv;
        logic [7:0] sv;
        logic [7:0] cv;
        case ($urandom_range(0, 9))
            0:       wv = 5'd0;
            1:       wv = 5'd1;
            2:       wv = 5'd16;
            3:       wv = 5'($urandom_range(17, 31));
            default: wv = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 11))
            0:       sv = 8'd0;
            1:       sv = 8'd255;
            2:       sv = 8'($urandom_range(9, 40));
            default: sv = 8'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 7))
            0:       cv = 8'd0;
            1:       cv = 8'd255;
            default: cv = 8'($urandom);
        endcase
        write_register(REG_WINDOW_SIZE, {3'($urandom_range(0, 7)), wv});
        write_register(REG_FRAME_STRIDE, sv);
        write_register(REG_SCORE_CUTOFF, cv);
        settings_used++;
    endtask

    // Mostly well-formed runs (clear, frames, evaluate) with random content, some runs
    // left open across a register change so the phases wrap on the new setting, and some
    // bursts of arbitrary requests.
    task automatic test_random_windows();
        bit         open_run;
        int         runs;
        logic [1:0] act;
        open_run = 1'b0;
        while (requests_sent < ITEM_TARGET) begin
            drain_results();
            pick_settings();
            if (requests_sent >= QUIET_FROM) idle_on = 1'b0;
            runs = $urandom_range(2, 6);
            for (int r = 0; r < runs && requests_sent < ITEM_TARGET; r++) begin
                if (open_run) begin
                    send_frames(frame_budget());
                    send_request(ACT_EVAL, 8'($urandom));
                    open_run = 1'b0;
                end else if ($urandom_range(0, 9) < 2) begin
                    repeat ($urandom_range(3, 12)) begin
                        case ($urandom_range(0, 3))
                            0:       act = ACT_FRAME;
                            1:       act = ACT_EVAL;
                            2:       act = ACT_CLEAR;
                            default: act = ACT_NONE;
                        endcase
                        send_request(act, 8'($urandom));
                    end
                end else begin
                    send_request(ACT_CLEAR, 8'($urandom));
                    send_frames(frame_budget());
                    send_request(ACT_EVAL, 8'($urandom));
                    // a repeat evaluation must answer zeros
                    if ($urandom_range(0, 3) == 0) send_request(ACT_EVAL, 8'($urandom));
                end
            end
            // leave a run open: clear and frames now, evaluation after the next write
            if (requests_sent < ITEM_TARGET && $urandom_range(0, 1)) begin
                send_request(ACT_CLEAR, 8'($urandom));
                send_frames(frame_budget());
                open_run = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        clear_window_model();
        win_reg    = WINDOW_SIZE_RST;
        stride_reg = FRAME_STRIDE_RST;
        cutoff_reg = SCORE_CUTOFF_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_result_backpressure();
        test_random_windows();

        // let every result out, then watch a while for anything extra
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Summary: %0d requests across %0d register settings", requests_sent,
                 settings_used);
        $display("Summary: %0d reported evaluations, %0d detections, %0d stored scores",
                 evals_seen, detects_seen, stores_seen);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
